/* rtl/core/csvft_pkg.sv */
// ----------------------------------------------------------------------------
// csvft_pkg
// Shared types, character codes and helpers for the CSV field tokeniser.
// ----------------------------------------------------------------------------
package csvft_pkg;

	localparam int FIELD_BYTES_DEF  = 32;
	localparam int COLUMN_LIMIT_DEF = 255;

	// Field length and index width; covers every buffer size up to 63 bytes.
	localparam int LEN_W = 6;
	localparam int COL_W = 8;
	localparam int CMDQ_DEPTH = 2;

	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_QUOTE = 8'h22;

	typedef enum logic [1:0] {
		KIND_BYTE      = 2'd0,
		KIND_FIELD_END = 2'd1,
		KIND_ROW_END   = 2'd2
	} kind_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_input;
	} item_t;

	typedef struct packed {
		kind_t            kind;
		logic [7:0]       out_byte;
		logic             field_present;
		logic             field_truncated;
		logic [COL_W-1:0] row_columns;
		logic [COL_W-1:0] widest_row;
		logic             last;
	} token_t;

	// One emission job: an optional field, then an optional row end.
	typedef struct packed {
		logic             do_field;
		logic             do_row;
		logic             bank;
		logic [LEN_W-1:0] from_idx;
		logic [LEN_W-1:0] to_idx;
		logic             present;
		logic             truncated;
		logic [COL_W-1:0] cols;
		logic [COL_W-1:0] widest;
	} cmd_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_READ,
		B_BYTE,
		B_EOF,
		B_ROW
	} back_state_t;

	function automatic logic is_ws(input logic [7:0] b);
		return (b == 8'd32) || ((b >= 8'd9) && (b <= 8'd13));
	endfunction

endpackage

/* rtl/core/csvft_ram.sv */
// ----------------------------------------------------------------------------
// csvft_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module csvft_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* rtl/core/csvft_front.sv */
// ----------------------------------------------------------------------------
// csvft_front
// Parser front end: tracks quoting and trimming, fills the field buffer and
// posts one emission job for each field or row that a delimiter or flush closes.
// ----------------------------------------------------------------------------
module csvft_front #(
	parameter int FIELD_BYTES  = csvft_pkg::FIELD_BYTES_DEF,
	parameter int COLUMN_LIMIT = csvft_pkg::COLUMN_LIMIT_DEF,
	localparam int IDX_W = (FIELD_BYTES > 1) ? $clog2(FIELD_BYTES) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  csvft_pkg::item_t   item,
	output logic               item_stall,
	output logic               push,
	output csvft_pkg::cmd_t    cmd,
	input  logic               done,
	output logic               wr_en,
	output logic [IDX_W:0]     wr_addr,
	output logic [7:0]         wr_data
);
	import csvft_pkg::*;

	localparam logic [COL_W-1:0] COL_CAP =
		COL_W'((COLUMN_LIMIT < 255) ? COLUMN_LIMIT : 255);
	localparam logic [LEN_W-1:0] FB = LEN_W'(FIELD_BYTES);

	logic [LEN_W-1:0] len_q, first_q, lastnz_q;
	logic [LEN_W-1:0] len_n, first_n, lastnz_n;
	logic             in_quote_q, qpend_q, crpend_q, have_text_q, started_q, ovf_q;
	logic             in_quote_n, qpend_n, crpend_n, have_text_n, started_n, ovf_n;
	logic [COL_W-1:0] cols_q, maxc_q, cols_n, maxc_n;
	logic             bank_q, bank_n;
	logic [1:0]       busy_q;

	logic             fire, ws, app, unq, end_fld, end_row;
	logic [7:0]       b;
	logic [COL_W-1:0] cols_inc, row_cnt, max_new;

	// Two buffer banks: at most two jobs may be owed to the back end.
	assign item_stall = (busy_q == 2'd2);
	assign fire       = item_valid && !item_stall;
	assign b          = item.in_byte;
	assign ws         = is_ws(b);
	assign cols_inc   = (cols_q < COL_CAP) ? cols_q + COL_W'(1) : cols_q;

	always_comb begin
		len_n       = len_q;
		first_n     = first_q;
		lastnz_n    = lastnz_q;
		in_quote_n  = in_quote_q;
		qpend_n     = qpend_q;
		crpend_n    = crpend_q;
		have_text_n = have_text_q;
		started_n   = started_q;
		ovf_n       = ovf_q;
		cols_n      = cols_q;
		maxc_n      = maxc_q;
		bank_n      = bank_q;
		app         = 1'b0;
		unq         = 1'b0;
		end_fld     = 1'b0;
		end_row     = 1'b0;
		row_cnt     = cols_q;
		max_new     = maxc_q;
		cmd         = '0;
		wr_en       = 1'b0;
		wr_addr     = {bank_q, len_q[IDX_W-1:0]};
		wr_data     = b;

		if (item.end_of_input) begin
			crpend_n = 1'b0;
			end_fld  = started_q;
			end_row  = (started_q ? cols_inc : cols_q) != '0;
		end else if (crpend_q && b == CH_LF) begin
			crpend_n = 1'b0;
		end else begin
			crpend_n = 1'b0;
			if (qpend_q) begin
				qpend_n = 1'b0;
				if (b == CH_QUOTE) begin
					app = 1'b1;
				end else begin
					in_quote_n = 1'b0;
					unq        = 1'b1;
				end
			end else if (in_quote_q) begin
				if (b == CH_QUOTE) begin
					qpend_n = 1'b1;
				end else begin
					app = 1'b1;
				end
			end else begin
				unq = 1'b1;
			end
		end

		if (unq) begin
			if (b == CH_COMMA || b == CH_CR || b == CH_LF) begin
				end_fld = 1'b1;
				if (b != CH_COMMA) begin
					end_row  = 1'b1;
					crpend_n = (b == CH_CR);
				end
			end else if (b == CH_QUOTE) begin
				in_quote_n = 1'b1;
				started_n  = 1'b1;
			end else if (ws) begin
				app = have_text_q;
			end else begin
				have_text_n = 1'b1;
				app         = 1'b1;
			end
		end

		if (app) begin
			started_n = 1'b1;
			if (len_q < FB) begin
				wr_en = fire;
				if (!ws) begin
					if (lastnz_q == '0) begin
						first_n = len_q;
					end
					lastnz_n = len_q + LEN_W'(1);
				end
				len_n = len_q + LEN_W'(1);
			end else begin
				ovf_n = 1'b1;
			end
		end

		if (end_fld) begin
			cmd.do_field  = 1'b1;
			cmd.from_idx  = have_text_q ? first_q : '0;
			cmd.to_idx    = have_text_q ? lastnz_q : len_q;
			cmd.present   = started_q;
			cmd.truncated = ovf_q;
			cols_n        = cols_inc;
			row_cnt       = cols_inc;
			bank_n        = !bank_q;
		end

		if (end_row) begin
			max_new    = (row_cnt > maxc_q) ? row_cnt : maxc_q;
			cmd.do_row = 1'b1;
			cmd.cols   = row_cnt;
			cmd.widest = max_new;
			cols_n     = '0;
			maxc_n     = max_new;
		end

		// A field end or a flush starts the next field from scratch.
		if (end_fld || item.end_of_input) begin
			len_n       = '0;
			first_n     = '0;
			lastnz_n    = '0;
			have_text_n = 1'b0;
			started_n   = 1'b0;
			ovf_n       = 1'b0;
			in_quote_n  = 1'b0;
			qpend_n     = 1'b0;
		end
		if (item.end_of_input) begin
			cols_n = '0;
		end

		cmd.bank = bank_q;
	end

	assign push = fire && (end_fld || end_row);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			first_q     <= '0;
			lastnz_q    <= '0;
			in_quote_q  <= 1'b0;
			qpend_q     <= 1'b0;
			crpend_q    <= 1'b0;
			have_text_q <= 1'b0;
			started_q   <= 1'b0;
			ovf_q       <= 1'b0;
			cols_q      <= '0;
			maxc_q      <= '0;
			bank_q      <= 1'b0;
			busy_q      <= '0;
		end else begin
			if (fire) begin
				len_q       <= len_n;
				first_q     <= first_n;
				lastnz_q    <= lastnz_n;
				in_quote_q  <= in_quote_n;
				qpend_q     <= qpend_n;
				crpend_q    <= crpend_n;
				have_text_q <= have_text_n;
				started_q   <= started_n;
				ovf_q       <= ovf_n;
				cols_q      <= cols_n;
				maxc_q      <= maxc_n;
				bank_q      <= bank_n;
			end
			busy_q <= busy_q + 2'(push) - 2'(done);
		end
	end

	a_busy_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q != 2'd3)
		else $error("front: more jobs owed than buffer banks");

endmodule

/* rtl/core/csvft_cmdq.sv */
// ----------------------------------------------------------------------------
// csvft_cmdq
// Two-entry job queue between the parser front and the emitter back.
// ----------------------------------------------------------------------------
module csvft_cmdq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  csvft_pkg::cmd_t  push_cmd,
	input  logic             pop,
	output logic             head_valid,
	output csvft_pkg::cmd_t  head
);
	import csvft_pkg::*;

	localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
	localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

	cmd_t             mem_q [CMDQ_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != CNT_W'(CMDQ_DEPTH)) || pop)
		else $error("cmdq: job pushed into a full queue");

	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("cmdq: pop from an empty queue");

endmodule

/* rtl/core/csvft_back.sv */
// ----------------------------------------------------------------------------
// csvft_back
// Emitter back end: replays each job as field bytes from the buffer and a
// field-end token where it holds a field, and a row-end token where it closes a row, through one output register.
// ----------------------------------------------------------------------------
module csvft_back #(
	parameter int FIELD_BYTES = csvft_pkg::FIELD_BYTES_DEF,
	localparam int IDX_W = (FIELD_BYTES > 1) ? $clog2(FIELD_BYTES) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  csvft_pkg::cmd_t    head,
	output logic               pop,
	output logic               done,
	output logic               rd_en,
	output logic [IDX_W:0]     rd_addr,
	input  logic [7:0]         rd_data,
	output logic               token_valid,
	input  logic               token_stall,
	output csvft_pkg::token_t  token
);
	import csvft_pkg::*;

	back_state_t      state_q, state_n;
	cmd_t             cmd_q, cmd_n;
	logic [LEN_W-1:0] ptr_q, ptr_n, ptr_inc;
	logic             out_valid_q, can_load, load;
	token_t           out_q, out_n;

	assign can_load = !out_valid_q || !token_stall;
	assign ptr_inc  = ptr_q + LEN_W'(1);

	always_comb begin
		state_n = state_q;
		cmd_n   = cmd_q;
		ptr_n   = ptr_q;
		pop     = 1'b0;
		done    = 1'b0;
		rd_en   = 1'b0;
		rd_addr = {cmd_q.bank, ptr_q[IDX_W-1:0]};
		load    = 1'b0;
		out_n   = '0;

		unique case (state_q)
			B_IDLE: begin
				if (head_valid) begin
					pop   = 1'b1;
					cmd_n = head;
					ptr_n = head.from_idx;
					if (!head.do_field) begin
						state_n = B_ROW;
					end else if (head.from_idx < head.to_idx) begin
						state_n = B_READ;
					end else begin
						state_n = B_EOF;
					end
				end
			end
			B_READ: begin
				rd_en   = 1'b1;
				state_n = B_BYTE;
			end
			B_BYTE: begin
				// Read data holds while stalled; prefetch next byte on a load.
				if (can_load) begin
					load         = 1'b1;
					out_n.kind   = KIND_BYTE;
					out_n.out_byte = rd_data;
					ptr_n        = ptr_inc;
					if (ptr_inc < cmd_q.to_idx) begin
						rd_en   = 1'b1;
						rd_addr = {cmd_q.bank, ptr_inc[IDX_W-1:0]};
					end else begin
						state_n = B_EOF;
					end
				end
			end
			B_EOF: begin
				if (can_load) begin
					load                  = 1'b1;
					out_n.kind            = KIND_FIELD_END;
					out_n.field_present   = cmd_q.present;
					out_n.field_truncated = cmd_q.truncated;
					out_n.last            = !cmd_q.do_row;
					if (cmd_q.do_row) begin
						state_n = B_ROW;
					end else begin
						state_n = B_IDLE;
						done    = 1'b1;
					end
				end
			end
			B_ROW: begin
				if (can_load) begin
					load              = 1'b1;
					out_n.kind        = KIND_ROW_END;
					out_n.row_columns = cmd_q.cols;
					out_n.widest_row  = cmd_q.widest;
					out_n.last        = 1'b1;
					state_n           = B_IDLE;
					done              = 1'b1;
				end
			end
			default: begin
				state_n = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!token_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cmd_q <= cmd_n;
		ptr_q <= ptr_n;
		if (load) begin
			out_q <= out_n;
		end
	end

	assign token_valid = out_valid_q;
	assign token       = out_q;

	a_row_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(token_valid && token.kind == KIND_ROW_END) |-> token.last)
		else $error("back: row end not marked last");

	a_byte_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(token_valid && token.kind == KIND_BYTE) |-> !token.last)
		else $error("back: field byte marked last");

	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> token_valid && token.last)
		else $error("back: job retired without its final token");

endmodule

/* rtl/core/csv_field_tokenizer_unit.sv */
// ----------------------------------------------------------------------------
// csv_field_tokenizer_unit
// Splits a byte stream into comma-separated fields and CR/LF/CRLF rows.
// ----------------------------------------------------------------------------
// Usage:
//  - item channel: one request per text byte, or one with end_of_input set
//    to flush the pending field and row and start afresh.
//  - token channel: field bytes, then an end-of-field token, then an
//    end-of-row token where a row closes; 'last' marks the final token a
//    request caused. Requests that cause nothing give no tokens.
//  - An ordinary byte is taken at once unless item_stall is high. A
//    delimiter posts a job that the emitter plays out at one token per
//    cycle while token_stall is low: it fetches the job, reads the
//    field's first kept byte where it has any, then gives the kept bytes,
//    an end-of-field token and, for a row end, an end-of-row token.
//  - The field buffer has two banks, so at most two delimited fields can be
//    owed to the emitter; once two are owed, further requests wait
//    (item_stall high) until the older job is done.
//  - token_stall freezes the output register; bytes keep being accepted
//    until both buffer banks are owed.
//  - Reset clears all parse state and counters; buffer contents are left
//    as they are, since only bytes written for the current field are read.
// ----------------------------------------------------------------------------
module csv_field_tokenizer_unit #(
	parameter int FIELD_BYTES  = csvft_pkg::FIELD_BYTES_DEF,
	parameter int COLUMN_LIMIT = csvft_pkg::COLUMN_LIMIT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  csvft_pkg::item_t   item,
	output logic               token_valid,
	input  logic               token_stall,
	output csvft_pkg::token_t  token
);
	import csvft_pkg::*;

	localparam int IDX_W     = (FIELD_BYTES > 1) ? $clog2(FIELD_BYTES) : 1;
	// One bank per outstanding field, addressed as {bank, index}.
	localparam int RAM_DEPTH = 2 * (2 ** IDX_W);

	logic           push, pop, done, head_valid;
	cmd_t           push_cmd, head;
	logic           wr_en, rd_en;
	logic [IDX_W:0] wr_addr, rd_addr;
	logic [7:0]     wr_data, rd_data;

	// Front: parse state, buffer fill, one job per closed field or row.
	csvft_front #(
		.FIELD_BYTES  (FIELD_BYTES),
		.COLUMN_LIMIT (COLUMN_LIMIT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_stall (item_stall),
		.push       (push),
		.cmd        (push_cmd),
		.done       (done),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data)
	);

	// Short job queue, lets the front run ahead of a stalled emitter.
	csvft_cmdq u_cmdq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// Field buffer, two banks.
	csvft_ram #(
		.WIDTH (8),
		.DEPTH (RAM_DEPTH)
	) u_buf (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Back: replays jobs as tokens through the output register.
	csvft_back #(
		.FIELD_BYTES (FIELD_BYTES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head        (head),
		.pop         (pop),
		.done        (done),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.rd_data     (rd_data),
		.token_valid (token_valid),
		.token_stall (token_stall),
		.token       (token)
	);

endmodule

/* bench/csv_field_tokenizer_unit_tb.sv */
// ----------------------------------------------------------------------------
// csv_field_tokenizer_unit_tb
// Self-checking bench for the CSV field tokeniser. A short table of directed
// requests (null fields, doubled and trailing quotes, blank trimming, an
// over-long field, CR/LF handling, end-of-input flushes) is followed by
// random CSV-shaped traffic and a row wide enough to saturate the column
// count. Every token is checked field by field against the table or a
// behavioural bench tokeniser; random traffic runs under three idling mixes.
// ----------------------------------------------------------------------------
module csv_field_tokenizer_unit_tb;
	import csvft_pkg::*;

	localparam int FIELD_CAP        = FIELD_BYTES_DEF;
	localparam int COL_CAP          = (COLUMN_LIMIT_DEF < 255) ? COLUMN_LIMIT_DEF : 255;
	localparam int RANDOM_PER_PHASE = 45;    // random requests per idling mix
	localparam int QUIET_LIMIT      = 2000;  // cycles with no transfer on either side
	localparam int DRAIN_CYCLES     = 40;    // longest job is 34 tokens plus fetch

	// one row of the directed table; typed rows carry their tokens written out
	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_input;
		logic [7:0] reps;
		logic       typed;
		logic [1:0] n_typed;
		token_t     t0;
		token_t     t1;
	} step_t;

	logic   clk          = 1'b0;
	logic   arst_n       = 1'b0;
	logic   item_valid   = 1'b0;
	logic   item_stall;
	item_t  item         = '0;
	logic   token_valid;
	logic   token_stall  = 1'b0;
	token_t token;

	int send_idle_pct = 0;
	int stall_pct     = 0;
	int fails         = 0;
	int quiet_cycles  = 0;

	step_t  steps[$];
	item_t  script[$];      // random requests waiting to be sent
	token_t batch[$];       // tokens caused by the request just accepted
	token_t tokens_due[$];  // tokens still owed by the block, oldest first

	// tokeniser state as the bench sees it
	logic [7:0] fbuf [FIELD_CAP];
	int flen, first_ix, last_ix;
	bit in_q, q_pend, cr_pend, seen_text, started, ovf;
	int row_fields, widest;

	csv_field_tokenizer_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.token_valid (token_valid),
		.token_stall (token_stall),
		.token       (token)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Behavioural tokeniser
	// ------------------------------------------------------------------------

	// blanks: HT, LF, VT, FF, CR and space
	function automatic bit blank_byte(input logic [7:0] b);
		return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
	endfunction

	function automatic token_t tok(input kind_t k, input logic pres, input logic trunc,
			input logic [7:0] cols, input logic [7:0] wide, input logic fin);
		token_t t;
		t = '0;
		t.kind            = k;
		t.field_present   = pres;
		t.field_truncated = trunc;
		t.row_columns     = cols;
		t.widest_row      = wide;
		t.last            = fin;
		return t;
	endfunction

	function automatic void put_byte_token(input logic [7:0] b);
		token_t t;
		t = tok(KIND_BYTE, 1'b0, 1'b0, 8'd0, 8'd0, 1'b0);
		t.out_byte = b;
		batch.push_back(t);
	endfunction

	function automatic void reset_field();
		flen      = 0;
		first_ix  = 0;
		last_ix   = 0;
		seen_text = 1'b0;
		started   = 1'b0;
		ovf       = 1'b0;
		in_q      = 1'b0;
		q_pend    = 1'b0;
	endfunction

	// bytes past the buffer are dropped but still mark the field truncated
	function automatic void buffer_byte(input logic [7:0] b);
		started = 1'b1;
		if (flen < FIELD_CAP) begin
			fbuf[flen] = b;
			if (!blank_byte(b)) begin
				if (last_ix == 0)
					first_ix = flen;
				last_ix = flen + 1;
			end
			flen++;
		end else begin
			ovf = 1'b1;
		end
	endfunction

	// trimming applies only once unquoted text has been seen
	function automatic void close_field();
		int lo, hi;
		lo = 0;
		hi = flen;
		if (started) begin
			if (seen_text) begin
				lo = first_ix;
				hi = last_ix;
			end
			for (int i = lo; i < hi; i++)
				put_byte_token(fbuf[i]);
		end
		batch.push_back(tok(KIND_FIELD_END, started, ovf, 8'd0, 8'd0, 1'b0));
		if (row_fields < COL_CAP)
			row_fields++;
		reset_field();
	endfunction

	function automatic void close_row();
		if (row_fields > widest)
			widest = row_fields;
		batch.push_back(tok(KIND_ROW_END, 1'b0, 1'b0, 8'(row_fields), 8'(widest), 1'b0));
		row_fields = 0;
	endfunction

	function automatic void scan_unquoted(input logic [7:0] b);
		if (b == CH_COMMA || b == CH_CR || b == CH_LF) begin
			close_field();
			if (b != CH_COMMA) begin
				close_row();
				cr_pend = (b == CH_CR);
			end
		end else if (b == CH_QUOTE) begin
			in_q    = 1'b1;
			started = 1'b1;
		end else if (blank_byte(b)) begin
			if (seen_text)
				buffer_byte(b);
		end else begin
			seen_text = 1'b1;
			buffer_byte(b);
		end
	endfunction

	// works out the tokens one accepted request causes, into batch
	function automatic void tokenise(input item_t it);
		token_t t;
		batch.delete();
		if (it.end_of_input) begin
			cr_pend = 1'b0;
			q_pend  = 1'b0;
			in_q    = 1'b0;
			if (started)
				close_field();
			if (row_fields > 0)
				close_row();
			reset_field();
			row_fields = 0;
		end else if (cr_pend && it.in_byte == CH_LF) begin
			cr_pend = 1'b0;  // LF of a CRLF pair
		end else begin
			cr_pend = 1'b0;
			if (q_pend) begin
				q_pend = 1'b0;
				if (it.in_byte == CH_QUOTE) begin
					buffer_byte(it.in_byte);
				end else begin
					in_q = 1'b0;
					scan_unquoted(it.in_byte);
				end
			end else if (in_q) begin
				if (it.in_byte == CH_QUOTE)
					q_pend = 1'b1;
				else
					buffer_byte(it.in_byte);
			end else begin
				scan_unquoted(it.in_byte);
			end
		end
		if (batch.size() > 0) begin
			t = batch.pop_back();
			t.last = 1'b1;
			batch.push_back(t);
		end
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus building
	// ------------------------------------------------------------------------

	// n < 0: tokens come from the tokeniser; otherwise t0/t1 are the tokens
	function automatic void add_step(input logic [7:0] b, input logic eoi, input int reps,
			input int n, input token_t t0 = '0, input token_t t1 = '0);
		step_t s;
		s.in_byte      = b;
		s.end_of_input = eoi;
		s.reps         = 8'(reps);
		s.typed        = (n >= 0);
		s.n_typed      = (n >= 0) ? 2'(n) : 2'd0;
		s.t0           = t0;
		s.t1           = t1;
		steps.push_back(s);
	endfunction

	function automatic void push_byte(input logic [7:0] b);
		item_t it;
		it.in_byte      = b;
		it.end_of_input = 1'b0;
		script.push_back(it);
	endfunction

	// the byte lane carries junk on a flush; the block must ignore it
	function automatic void push_end();
		item_t it;
		it.in_byte      = 8'($urandom_range(255));
		it.end_of_input = 1'b1;
		script.push_back(it);
	endfunction

	// padding blanks that are not row delimiters
	function automatic logic [7:0] pad_byte();
		case ($urandom_range(3))
			0: return 8'h09;
			1: return 8'h0B;
			2: return 8'h0C;
			default: return 8'h20;
		endcase
	endfunction

	function automatic logic [7:0] text_byte();
		logic [7:0] b;
		if ($urandom_range(4) == 0)
			return pad_byte();
		do
			b = 8'($urandom_range(255));
		while (b == CH_COMMA || b == CH_CR || b == CH_LF || b == CH_QUOTE);
		return b;
	endfunction

	// inside quotes anything goes bar the quote itself
	function automatic logic [7:0] quoted_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(255));
		while (b == CH_QUOTE);
		return b;
	endfunction

	function automatic void plan_field();
		int style, n;
		style = $urandom_range(99);
		n = ($urandom_range(19) == 0) ? $urandom_range(FIELD_CAP + 1, FIELD_CAP + 12)
		                              : $urandom_range(0, 6);
		if ($urandom_range(3) == 0)
			repeat ($urandom_range(1, 3)) push_byte(pad_byte());
		if (style < 45) begin
			repeat (n) push_byte(text_byte());
		end else if (style < 85) begin
			push_byte(CH_QUOTE);
			repeat (n) begin
				if ($urandom_range(7) == 0) begin
					push_byte(CH_QUOTE);
					push_byte(CH_QUOTE);
				end else begin
					push_byte(quoted_byte());
				end
			end
			push_byte(CH_QUOTE);
		end
		// the remaining styles leave the field null
		if ($urandom_range(3) == 0)
			repeat ($urandom_range(1, 3)) push_byte(pad_byte());
	endfunction

	// mostly well-formed rows; some raw noise and broken quoting
	function automatic void plan_record();
		int pick, cols;
		pick = $urandom_range(99);
		if (pick < 70) begin
			cols = $urandom_range(1, 5);
			for (int c = 0; c < cols; c++) begin
				if (c > 0)
					push_byte(CH_COMMA);
				plan_field();
			end
			case ($urandom_range(4))
				0: push_byte(CH_LF);
				1: push_byte(CH_CR);
				2: begin
					push_byte(CH_CR);
					push_byte(CH_LF);
				end
				3: push_byte(text_byte());  // row runs on into the next record
				default: push_end();
			endcase
		end else if (pick < 85) begin
			repeat ($urandom_range(1, 8)) push_byte(8'($urandom_range(255)));
		end else if (pick < 95) begin
			push_byte(CH_QUOTE);
			repeat ($urandom_range(0, 4)) push_byte(text_byte());
			if ($urandom_range(1)) begin
				// text straight after the closing quote
				push_byte(CH_QUOTE);
				repeat ($urandom_range(1, 3)) push_byte(text_byte());
				push_byte(CH_LF);
			end else begin
				push_end();  // quote never closed
			end
		end else begin
			push_end();
		end
	endfunction

	// ------------------------------------------------------------------------
	// Request side: driven on the falling edge, taken on the rising edge
	// ------------------------------------------------------------------------

	task automatic send_item(input item_t it, input bit typed, input int n_typed,
			input token_t t0, input token_t t1);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item       <= it;
		item_valid <= 1'b1;
		do
			@(posedge clk);
		while (item_stall);
		// request taken at this edge
		tokenise(it);
		if (typed) begin
			if (n_typed > 0)
				tokens_due.push_back(t0);
			if (n_typed > 1)
				tokens_due.push_back(t1);
		end else begin
			foreach (batch[k])
				tokens_due.push_back(batch[k]);
		end
		@(negedge clk);
	endtask

	task automatic play_script(inout int sent);
		item_t it;
		while (script.size() > 0) begin
			it = script.pop_front();
			send_item(it, 1'b0, 0, '0, '0);
			sent++;
		end
	endtask

	// ------------------------------------------------------------------------
	// Token side: random stall, checked against the oldest token owed
	// ------------------------------------------------------------------------

	always @(negedge clk)
		token_stall <= ($urandom_range(99) < stall_pct);

	task automatic check_field(input string what, input int exp_v, input int got_v);
		if (exp_v != got_v) begin
			$display("%0t: token %s mismatch, expected %0d, got %0d", $time, what,
				exp_v, got_v);
			fails++;
		end
	endtask

	always @(posedge clk) begin
		token_t exp_t;
		if (arst_n && token_valid && !token_stall) begin
			if (tokens_due.size() == 0) begin
				$display("%0t: unexpected token, expected none, got kind %0d byte %0d",
					$time, token.kind, token.out_byte);
				fails++;
			end else begin
				exp_t = tokens_due.pop_front();
				check_field("kind", int'(exp_t.kind), int'(token.kind));
				check_field("out_byte", int'(exp_t.out_byte), int'(token.out_byte));
				check_field("field_present", int'(exp_t.field_present),
					int'(token.field_present));
				check_field("field_truncated", int'(exp_t.field_truncated),
					int'(token.field_truncated));
				check_field("row_columns", int'(exp_t.row_columns),
					int'(token.row_columns));
				check_field("widest_row", int'(exp_t.widest_row), int'(token.widest_row));
				check_field("last", int'(exp_t.last), int'(token.last));
			end
		end
	end

	// watchdog: a run of cycles with nothing moving on either side is a hang
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (token_valid && !token_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------

	initial begin
		int sent;
		item_t it;

		// Directed table, from reset. Rows with a token count have their
		// tokens written out; the rest go through the tokeniser.
		// empty line: one null field, a row of one column
		add_step(CH_LF, 1'b0, 1, 2, tok(KIND_FIELD_END, 1'b0, 1'b0, 8'd0, 8'd0, 1'b0),
			tok(KIND_ROW_END, 1'b0, 1'b0, 8'd1, 8'd1, 1'b1));
		// open quote, then a doubled quote giving a literal quote
		add_step(CH_QUOTE, 1'b0, 3, 0);
		add_step(8'hFF, 1'b0, 1, 0);
		// quote as the very last byte: closes the field on the flush
		add_step(CH_QUOTE, 1'b0, 1, 0);
		add_step(8'h00, 1'b1, 1, -1);
		// leading blanks skipped, trailing blank trimmed off the text
		add_step(8'h20, 1'b0, 1, 0);
		add_step(8'h09, 1'b0, 1, 0);
		add_step(8'h00, 1'b0, 1, 0);
		add_step(8'h20, 1'b0, 1, 0);
		add_step(CH_COMMA, 1'b0, 1, -1);
		// CR ends a row of a text field and a null field; its LF is swallowed
		add_step(CH_CR, 1'b0, 1, 2, tok(KIND_FIELD_END, 1'b0, 1'b0, 8'd0, 8'd0, 1'b0),
			tok(KIND_ROW_END, 1'b0, 1'b0, 8'd2, 8'd2, 1'b1));
		add_step(CH_LF, 1'b0, 1, 0);
		// flush with nothing pending gives nothing, whatever the byte lane holds
		add_step(8'hA5, 1'b1, 1, 0);
		// 40 bytes of 'x' into a 32-byte buffer: truncated, largest token burst
		add_step(8'h78, 1'b0, 40, 0);
		add_step(CH_LF, 1'b0, 1, -1);
		// quote still open at end of input: flushed as it stands
		add_step(CH_QUOTE, 1'b0, 1, 0);
		add_step(8'h61, 1'b0, 1, 0);
		add_step(8'h00, 1'b1, 1, -1);
		// CR CR is two empty rows; the flush then clears the pending CR
		add_step(CH_CR, 1'b0, 2, -1);
		add_step(8'h5A, 1'b1, 1, 0);

		reset_field();
		cr_pend    = 1'b0;
		row_fields = 0;
		widest     = 0;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// three idling mixes: busy receiver, then slow sender, then none
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 21 : (ph == 1) ? 76 : 0;
			stall_pct     = (ph == 0) ? 76 : (ph == 1) ? 21 : 0;
			if (ph == 0) begin
				foreach (steps[s]) begin
					it.in_byte      = steps[s].in_byte;
					it.end_of_input = steps[s].end_of_input;
					repeat (steps[s].reps)
						send_item(it, steps[s].typed, int'(steps[s].n_typed),
							steps[s].t0, steps[s].t1);
				end
			end
			sent = 0;
			while (sent < RANDOM_PER_PHASE) begin
				plan_record();
				play_script(sent);
			end
		end

		// one row wide enough to pin the column count at its ceiling
		push_end();
		repeat (COL_CAP + 1) push_byte(CH_COMMA);
		push_byte(CH_LF);
		play_script(sent);

		item_valid <= 1'b0;
		while (tokens_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fails == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
